FILE: design/key_matrix_scan_decoder_unit_macros.svh
// assertion macros for the key matrix scan decoder checker
// no dependencies; included by the checker file only
`ifndef KEY_MATRIX_SCAN_DECODER_UNIT_MACROS_SVH
`define KEY_MATRIX_SCAN_DECODER_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define KMSD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("kmsd check failed");

// next-cycle implication, disabled during reset
`define KMSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("kmsd check failed");

`endif

FILE: design/kmsd_pkg.sv
// shared types and constants for the key matrix scan decoder
// no dependencies; imported by every module of the block
`default_nettype none

package kmsd_pkg;

	localparam int KMSD_ROWS = 8;
	localparam int KMSD_COLS = 16;

	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 32;

	localparam logic [15:0] MOD_LO = 16'h00E0;
	localparam logic [15:0] MOD_HI = 16'h00E7;
	localparam logic [7:0]  KEY_LIMIT_RST = 8'd6;

	localparam logic KIND_LOAD   = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;
	localparam logic RES_KEY     = 1'b0;
	localparam logic RES_SUM     = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH,
		ST_SUM
	} kmsd_state_t;

	typedef struct packed {
		logic accept;
		logic scan;
		logic flush;
		logic sum;
	} kmsd_cmd_t;

	typedef struct packed {
		logic start_go;
		logic scan_done;
		logic hold_v;
		logic out_free;
		logic last_row;
	} kmsd_sts_t;

endpackage

`default_nettype wire

FILE: design/kmsd_ctrl.sv
// controller state machine of the key matrix scan decoder
// depends on kmsd_pkg; drives the datapath through kmsd_cmd_t
`default_nettype none

module kmsd_ctrl import kmsd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  kmsd_sts_t sts,
	output kmsd_cmd_t cmd
);

	kmsd_state_t state_q;
	kmsd_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.accept = 1'b1;
				if (sts.start_go) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				cmd.flush = 1'b1;
				if (!sts.hold_v || sts.out_free) begin
					state_d = sts.last_row ? ST_SUM : ST_IDLE;
				end
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: design/kmsd_dp.sv
// datapath of the key matrix scan decoder: key map memory, column walk,
// modifier and count registers, one held key and the output register; uses kmsd_pkg
`default_nettype none

module kmsd_dp import kmsd_pkg::*; #(
	parameter int ROWS = KMSD_ROWS,
	parameter int COLS = KMSD_COLS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_kind,
	input  logic [2:0]  in_row,
	input  logic [3:0]  in_col,
	input  logic [15:0] in_code,
	input  logic [15:0] in_sense,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  kmsd_cmd_t   cmd,
	output kmsd_sts_t   sts,
	input  logic        out_ready,
	output logic        out_valid,
	output logic        out_kind,
	output logic [15:0] out_key_code,
	output logic [7:0]  out_mods,
	output logic [7:0]  out_count,
	output logic        out_last
);

	localparam int DEPTH = ROWS * COLS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NB    = (COLS < 16) ? COLS : 16;
	localparam int JW    = $clog2(NB + 1);

	logic [15:0]   key_map_mem [DEPTH];
	logic [15:0]   rd_data_s2;
	logic          v_s2_q;
	logic [JW-1:0] j_q;
	logic [15:0]   sense_q;
	logic [2:0]    row_q;
	logic [7:0]    key_limit_q;
	logic [7:0]    mod_q;
	logic [7:0]    cnt_q;
	logic          hold_v_q;
	logic [15:0]   hold_code_q;
	logic          out_valid_q;

	logic          row_ok;
	logic          col_ok;
	logic          load_en;
	logic          start_en;
	logic [31:0]   wr_full;
	logic [31:0]   rd_full;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	logic          out_free;
	logic          last_row;
	logic          hit;
	logic          is_mod;
	logic          emit;
	logic          stall;
	logic          adv;
	logic          issue;
	logic          scan_push;
	logic          flush_push;
	logic          sum_push;

	assign row_ok   = int'(in_row) < ROWS;
	assign col_ok   = int'(in_col) < COLS;
	assign load_en  = cmd.accept && in_valid && (in_kind == KIND_LOAD) && row_ok && col_ok;
	assign start_en = cmd.accept && sts.start_go;

	assign wr_full  = 32'(int'(in_row) * COLS + int'(in_col));
	assign rd_full  = 32'(int'(row_q) * COLS + (COLS - 1) - int'(j_q));
	assign wr_addr  = wr_full[AW-1:0];
	assign rd_addr  = rd_full[AW-1:0];

	assign out_free = !out_valid_q || out_ready;
	assign last_row = int'(row_q) == (ROWS - 1);

	assign hit    = v_s2_q && (rd_data_s2 != 16'd0);
	assign is_mod = (rd_data_s2 >= MOD_LO) && (rd_data_s2 <= MOD_HI);
	assign emit   = cmd.scan && hit && !is_mod && (cnt_q < key_limit_q);
	assign stall  = emit && hold_v_q && !out_free;
	assign adv    = cmd.scan && !stall;
	assign issue  = adv && (j_q != JW'(NB));

	assign scan_push  = adv && emit && hold_v_q;
	assign flush_push = cmd.flush && hold_v_q && out_free;
	assign sum_push   = cmd.sum && out_free;

	assign sts.start_go  = in_valid && (in_kind == KIND_SAMPLE) && row_ok;
	assign sts.scan_done = (j_q == JW'(NB)) && !v_s2_q;
	assign sts.hold_v    = hold_v_q;
	assign sts.out_free  = out_free;
	assign sts.last_row  = last_row;

	assign out_valid = out_valid_q;

	// key map, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (load_en) begin
			key_map_mem[wr_addr] <= in_code;
		end
		if (issue) begin
			rd_data_s2 <= key_map_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_limit_q <= KEY_LIMIT_RST;
			mod_q       <= '0;
			cnt_q       <= '0;
			hold_v_q    <= 1'b0;
			v_s2_q      <= 1'b0;
			j_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				key_limit_q <= cfg_wr_data;
			end
			if (start_en) begin
				j_q    <= '0;
				v_s2_q <= 1'b0;
			end else if (adv) begin
				if (issue) begin
					j_q    <= j_q + JW'(1);
					v_s2_q <= sense_q[0];
				end else begin
					v_s2_q <= 1'b0;
				end
			end
			if (adv && hit) begin
				if (is_mod) begin
					mod_q <= mod_q | (8'd1 << rd_data_s2[3:0]);
				end else if (cnt_q < key_limit_q) begin
					cnt_q    <= cnt_q + 8'd1;
					hold_v_q <= 1'b1;
				end
			end
			if (flush_push) begin
				hold_v_q <= 1'b0;
			end
			if (sum_push) begin
				mod_q <= '0;
				cnt_q <= '0;
			end
			if (scan_push || flush_push || sum_push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_en) begin
			sense_q <= in_sense;
			row_q   <= in_row;
		end else if (issue) begin
			sense_q <= sense_q >> 1;
		end
		if (adv && emit) begin
			hold_code_q <= rd_data_s2;
		end
		if (scan_push || flush_push) begin
			out_kind     <= RES_KEY;
			out_key_code <= hold_code_q;
			out_mods     <= '0;
			out_count    <= '0;
			out_last     <= flush_push && !last_row;
		end else if (sum_push) begin
			out_kind     <= RES_SUM;
			out_key_code <= '0;
			out_mods     <= mod_q;
			out_count    <= cnt_q;
			out_last     <= 1'b1;
		end
	end

endmodule

`default_nettype wire

FILE: design/key_matrix_scan_decoder_unit.sv
// key matrix scan decoder, top level: input and output streams, limit register
// Input stream s_axis: tuser selects a key map load or a row sample. A load writes one
// entry of the key map and gives no word. A sample walks the row's sense bits from
// bit 0 up, one column per cycle unless stalled, through the map read port, and gives one
// key word per mapped, pressed, non-modifier key while the per-scan count is below the limit.
// A sample of the last row adds a summary word (modifier mask and count) and clears both.
// Output stream m_axis: tlast marks the final word caused by one input word.
// A sample's walk is paced by the single map read port; a set last sense bit lengthens it,
// and a sample of the last row adds a step for the summary word.
// A key word waits in a holding register until the next key of the row or the end of the walk
// settles its tlast; it moves to the output register when the next key's code leaves the map
// read register, or in the flush state after the walk.
// s_axis_tready is high only while no sample is in progress; a finished word may still
// sit in the output register while the next input word is taken.
// When m_axis_tready is low the column walk stops at the next key word and holds
// until the output register drains; no word is lost. Reset clears the limit to 6 and the
// modifier mask and count to zero; the key map is not cleared and must be loaded before
// use. cfg_wr_en writes the limit; the user must do so only when idle, unchecked by the block.
`default_nettype none

module key_matrix_scan_decoder_unit import kmsd_pkg::*; #(
	parameter int ROWS = KMSD_ROWS,
	parameter int COLS = KMSD_COLS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// row_index, column_index, map_code, sense_bits, zero pad
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	// kind
	input  logic                 s_axis_tuser,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// key_code, modifier_bits, key_count
	output logic [M_TDATA_W-1:0] m_axis_tdata,
	// result_kind
	output logic                 m_axis_tuser,
	output logic                 m_axis_tlast,
	input  logic                 cfg_wr_en,
	input  logic [7:0]           cfg_wr_data
);

	kmsd_cmd_t   cmd;
	kmsd_sts_t   sts;
	logic [15:0] key_code;
	logic [7:0]  mods;
	logic [7:0]  count;

	assign s_axis_tready = cmd.accept;
	assign m_axis_tdata  = {count, mods, key_code};

	kmsd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	kmsd_dp #(
		.ROWS (ROWS),
		.COLS (COLS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_kind      (s_axis_tuser),
		.in_row       (s_axis_tdata[2:0]),
		.in_col       (s_axis_tdata[6:3]),
		.in_code      (s_axis_tdata[22:7]),
		.in_sense     (s_axis_tdata[38:23]),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.cmd          (cmd),
		.sts          (sts),
		.out_ready    (m_axis_tready),
		.out_valid    (m_axis_tvalid),
		.out_kind     (m_axis_tuser),
		.out_key_code (key_code),
		.out_mods     (mods),
		.out_count    (count),
		.out_last     (m_axis_tlast)
	);

endmodule

`default_nettype wire

FILE: design/kmsd_chk.sv
// port-level checker for the key matrix scan decoder, bound to the top level
// depends on kmsd_pkg and key_matrix_scan_decoder_unit_macros.svh
`default_nettype none
`include "key_matrix_scan_decoder_unit_macros.svh"

module kmsd_chk import kmsd_pkg::*; (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 m_axis_tvalid,
	input wire logic                 m_axis_tready,
	input wire logic [M_TDATA_W-1:0] m_axis_tdata,
	input wire logic                 m_axis_tuser,
	input wire logic                 m_axis_tlast
);

	// stalled word stays and holds its payload
	`KMSD_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

	// summary word always closes the burst of its input word
	`KMSD_ASSERT_SAME(a_sum_last, clk, arst_n, m_axis_tvalid && (m_axis_tuser == RES_SUM), m_axis_tlast)

	// key words carry a nonzero code and clear mask and count fields
	`KMSD_ASSERT_SAME(a_key_fields, clk, arst_n, m_axis_tvalid && (m_axis_tuser == RES_KEY), (m_axis_tdata[15:0] != 16'd0) && (m_axis_tdata[31:16] == 16'd0))

	// summary words carry a zero key code
	`KMSD_ASSERT_SAME(a_sum_fields, clk, arst_n, m_axis_tvalid && (m_axis_tuser == RES_SUM), m_axis_tdata[15:0] == 16'd0)

endmodule

bind key_matrix_scan_decoder_unit kmsd_chk u_kmsd_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

FILE: tb/tb_key_matrix_scan_decoder_unit.sv
// self-checking testbench for key_matrix_scan_decoder_unit: directed table, then random scans
// keeps its own copy of key map, modifier mask, count and limit to predict every output word
// depends on kmsd_pkg and the key_matrix_scan_decoder_unit top level
`default_nettype none

module tb_key_matrix_scan_decoder_unit;
	import kmsd_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 40;
	localparam int DIR_ROWS = 16;
	localparam int PHASE_ITEMS = 50;

	typedef struct packed {
		logic        rkind;
		logic [15:0] code;
		logic [7:0]  mods;
		logic [7:0]  cnt;
		logic        lst;
	} scan_word_t;

	typedef struct packed {
		logic        kind;
		logic [2:0]  row;
		logic [3:0]  col;
		logic [15:0] code;
		logic [15:0] sense;
		logic        typed;
		logic [7:0]  t_mods;
		logic [7:0]  t_cnt;
	} stim_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata;
	logic                 s_axis_tuser;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic                 m_axis_tuser;
	logic                 m_axis_tlast;
	logic                 cfg_wr_en;
	logic [7:0]           cfg_wr_data;

	logic [15:0] code_map [KMSD_ROWS*KMSD_COLS];
	logic [15:0] map_written [KMSD_ROWS];
	logic [7:0]  mod_mask;
	logic [7:0]  scan_count;
	logic [7:0]  limit_reg;
	scan_word_t  pending_words [$];

	stim_row_t dir_table [DIR_ROWS];
	int        errors;
	int        words_seen;
	int        cycle_cnt;
	logic      quiet;
	logic      hold_arm;
	logic      long_hold_done;

	key_matrix_scan_decoder_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// expected words for one accepted input word
	function automatic void decode_item(logic kind, logic [2:0] row, logic [3:0] col,
			logic [15:0] code, logic [15:0] sense);
		logic [15:0] c;
		scan_word_t  held;
		logic        have;
		int          j;
		have = 1'b0;
		held = '0;
		if (kind == KIND_LOAD) begin
			code_map[{row, col}] = code;
			map_written[row][col] = 1'b1;
		end else begin
			for (j = 0; j < KMSD_COLS; j++) begin
				if (sense[j]) begin
					c = code_map[{row, 4'(KMSD_COLS - 1 - j)}];
					if (c != 16'd0) begin
						if (c >= MOD_LO && c <= MOD_HI) begin
							mod_mask = mod_mask | (8'd1 << c[3:0]);
						end else if (scan_count < limit_reg) begin
							scan_count = scan_count + 8'd1;
							if (have)
								pending_words.push_back(held);
							held = '{rkind: RES_KEY, code: c, mods: 8'd0, cnt: 8'd0, lst: 1'b0};
							have = 1'b1;
						end
					end
				end
			end
			if (row == 3'(KMSD_ROWS - 1)) begin
				if (have)
					pending_words.push_back(held);
				held = '{rkind: RES_SUM, code: 16'd0, mods: mod_mask, cnt: scan_count, lst: 1'b0};
				have = 1'b1;
				mod_mask = 8'd0;
				scan_count = 8'd0;
			end
			if (have) begin
				held.lst = 1'b1;
				pending_words.push_back(held);
			end
		end
	endfunction

	// sense bits limited to columns already loaded
	function automatic logic [15:0] loaded_cols(logic [2:0] row);
		logic [15:0] m;
		int          j;
		for (j = 0; j < 16; j++)
			m[j] = map_written[row][15 - j];
		return m;
	endfunction

	function automatic logic [15:0] pick_code();
		int r;
		r = $urandom_range(0, 19);
		if (r < 5)
			return MOD_LO + 16'($urandom_range(0, 7));
		if (r < 7)
			return 16'd0;
		if (r == 7) begin
			case ($urandom_range(0, 4))
				0: return MOD_LO - 16'd1;
				1: return MOD_HI + 16'd1;
				2: return 16'hFFFF;
				3: return 16'h0100 | MOD_LO | 16'($urandom_range(0, 7));
				default: return 16'd1;
			endcase
		end
		return 16'($urandom_range(1, 65535));
	endfunction

	task automatic send_word(logic kind, logic [2:0] row, logic [3:0] col,
			logic [15:0] code, logic [15:0] sense, logic typed, scan_word_t typed_word);
		int n0;
		@(negedge clk);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid = 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser = kind;
		s_axis_tdata = {1'b0, sense, code, col, row};
		do
			@(posedge clk);
		while (!s_axis_tready);
		n0 = pending_words.size();
		decode_item(kind, row, col, code, sense);
		if (typed) begin
			while (pending_words.size() > n0)
				void'(pending_words.pop_back());
			pending_words.push_back(typed_word);
		end
	endtask

	task automatic send_load();
		logic [2:0] row;
		logic [3:0] col;
		int         k;
		row = 3'($urandom_range(0, KMSD_ROWS - 1));
		col = 4'($urandom_range(0, KMSD_COLS - 1));
		for (k = 0; k < 4 && map_written[row][col]; k++) begin
			row = 3'($urandom_range(0, KMSD_ROWS - 1));
			col = 4'($urandom_range(0, KMSD_COLS - 1));
		end
		send_word(KIND_LOAD, row, col, pick_code(), 16'($urandom), 1'b0, '0);
	endtask

	task automatic send_sample(logic [2:0] row);
		logic [15:0] s;
		int          r;
		r = $urandom_range(0, 9);
		if (r < 3)
			s = 16'hFFFF;
		else if (r < 5)
			s = 16'd1 << $urandom_range(0, 15);
		else
			s = 16'($urandom);
		send_word(KIND_SAMPLE, row, 4'($urandom), 16'($urandom), s & loaded_cols(row),
			1'b0, '0);
	endtask

	task automatic drain_and_set_limit(logic [7:0] v);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_wr_data = v;
		@(posedge clk);
		limit_reg = v;
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	task automatic run_phase(int n);
		int cnt;
		int r;
		int row;
		cnt = 0;
		while (cnt < n) begin
			r = $urandom_range(0, 9);
			if (r < 7) begin
				for (row = 0; row < KMSD_ROWS; row++) begin
					if ($urandom_range(0, 4) == 0) begin
						send_load();
						cnt++;
					end
					send_sample(3'(row));
					cnt++;
				end
			end else if (r < 9) begin
				send_load();
				cnt++;
			end else begin
				send_sample(3'($urandom_range(0, KMSD_ROWS - 1)));
				cnt++;
			end
		end
	endtask

	// output check
	always @(posedge clk) begin
		scan_word_t got;
		scan_word_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			words_seen = words_seen + 1;
			got = '{rkind: m_axis_tuser, code: m_axis_tdata[15:0], mods: m_axis_tdata[23:16],
				cnt: m_axis_tdata[31:24], lst: m_axis_tlast};
			if (pending_words.size() == 0) begin
				errors = errors + 1;
				$display("%0t: unexpected word kind=%0b code=%h mods=%h cnt=%0d last=%0b",
					$time, got.rkind, got.code, got.mods, got.cnt, got.lst);
			end else begin
				want = pending_words.pop_front();
				if (got.rkind !== want.rkind || got.code !== want.code ||
						got.mods !== want.mods || got.cnt !== want.cnt ||
						got.lst !== want.lst) begin
					errors = errors + 1;
					$display("%0t: mismatch expected kind=%0b code=%h mods=%h cnt=%0d last=%0b %s",
						$time, want.rkind, want.code, want.mods, want.cnt, want.lst,
						$sformatf("actual kind=%0b code=%h mods=%h cnt=%0d last=%0b",
						got.rkind, got.code, got.mods, got.cnt, got.lst));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// output side backpressure
	initial begin
		m_axis_tready = 1'b0;
		long_hold_done = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_arm && !long_hold_done) begin
				long_hold_done = 1'b1;
				m_axis_tready = 1'b0;
				repeat (400) @(negedge clk);
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				m_axis_tready = 1'b0;
				repeat ($urandom_range(1, 17)) @(negedge clk);
			end else begin
				m_axis_tready = 1'b1;
				repeat ($urandom_range(1, 24)) @(negedge clk);
			end
		end
	end

	initial begin
		scan_word_t tw;
		int         i;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 8'd0;
		quiet = 1'b0;
		hold_arm = 1'b0;
		mod_mask = 8'd0;
		scan_count = 8'd0;
		limit_reg = KEY_LIMIT_RST;
		for (i = 0; i < KMSD_ROWS * KMSD_COLS; i++)
			code_map[i] = 16'd0;
		for (i = 0; i < KMSD_ROWS; i++)
			map_written[i] = 16'd0;

		dir_table = '{
			'{KIND_SAMPLE, 3'd7, 4'd0,  16'h0000, 16'h0000, 1'b1, 8'h00, 8'd0},
			'{KIND_LOAD,   3'd0, 4'd15, 16'h0004, 16'h0000, 1'b0, 8'h00, 8'd0},
			'{KIND_LOAD,   3'd0, 4'd0,  16'hFFFF, 16'hFFFF, 1'b0, 8'h00, 8'd0},
			'{KIND_LOAD,   3'd0, 4'd14, 16'h00E0, 16'h0000, 1'b0, 8'h00, 8'd0},
			'{KIND_LOAD,   3'd0, 4'd13, 16'h00E7, 16'h0000, 1'b0, 8'h00, 8'd0},
			'{KIND_LOAD,   3'd0, 4'd12, 16'h0000, 16'h0000, 1'b0, 8'h00, 8'd0},
			'{KIND_LOAD,   3'd0, 4'd11, 16'h00DF, 16'h0000, 1'b0, 8'h00, 8'd0},
			'{KIND_LOAD,   3'd0, 4'd10, 16'h00E8, 16'h0000, 1'b0, 8'h00, 8'd0},
			'{KIND_LOAD,   3'd0, 4'd9,  16'h01E3, 16'h0000, 1'b0, 8'h00, 8'd0},
			'{KIND_LOAD,   3'd7, 4'd15, 16'h0005, 16'h0000, 1'b0, 8'h00, 8'd0},
			'{KIND_LOAD,   3'd7, 4'd0,  16'h00E3, 16'h0000, 1'b0, 8'h00, 8'd0},
			'{KIND_SAMPLE, 3'd0, 4'd15, 16'hFFFF, 16'h007F, 1'b0, 8'h00, 8'd0},
			'{KIND_SAMPLE, 3'd7, 4'd0,  16'h0000, 16'h8001, 1'b0, 8'h00, 8'd0},
			'{KIND_SAMPLE, 3'd0, 4'd0,  16'h0000, 16'h807F, 1'b0, 8'h00, 8'd0},
			'{KIND_SAMPLE, 3'd0, 4'd0,  16'h0000, 16'h8001, 1'b0, 8'h00, 8'd0},
			// limit reached: count stays at six, modifiers still gathered
			'{KIND_SAMPLE, 3'd7, 4'd0,  16'h0000, 16'h0000, 1'b1, 8'h81, 8'd6}
		};

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (i = 0; i < DIR_ROWS; i++) begin
			tw = '{rkind: RES_SUM, code: 16'd0, mods: dir_table[i].t_mods,
				cnt: dir_table[i].t_cnt, lst: 1'b1};
			send_word(dir_table[i].kind, dir_table[i].row, dir_table[i].col,
				dir_table[i].code, dir_table[i].sense, dir_table[i].typed, tw);
		end

		drain_and_set_limit(8'd0);
		run_phase(PHASE_ITEMS);
		drain_and_set_limit(8'd128);
		run_phase(PHASE_ITEMS);
		drain_and_set_limit(8'd255);
		hold_arm = 1'b1;
		run_phase(PHASE_ITEMS);
		drain_and_set_limit(8'd1);
		run_phase(PHASE_ITEMS);
		drain_and_set_limit(8'($urandom_range(2, 20)));
		run_phase(PHASE_ITEMS);
		drain_and_set_limit(8'($urandom_range(0, 255)));
		run_phase(PHASE_ITEMS);
		drain_and_set_limit(KEY_LIMIT_RST);
		quiet = 1'b1;
		run_phase(PHASE_ITEMS);

		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire
